FILE: rtl/necfan_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necfan_pkg
// Shared types, constants and helpers for the NEC IR fan control decoder.
// ----------------------------------------------------------------------------
package necfan_pkg;

    // Frame geometry
    localparam int CODE_BITS       = 32;
    localparam int MAX_ENTRIES     = 128;
    localparam int IDX_W           = $clog2(MAX_ENTRIES);
    localparam int LAST_DATA_ENTRY = 2 + 2 * CODE_BITS;
    localparam int MIN_FRAME       = 2 * CODE_BITS + 4;
    localparam int RPT_LAST_ENTRY  = 3;

    // Duration and window widths
    localparam int DUR_W   = 16;
    localparam int WIN_N   = 12;
    localparam int SLOT_W  = $clog2(WIN_N);
    localparam int NOM_W   = 14;
    localparam int NUM_W   = 21;
    localparam int DEN_W   = 15;
    localparam int BCNT_W  = $clog2(NUM_W);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK_EXCESS = 2'd2;

    localparam logic [5:0] TOL_RESET    = 6'd25;
    localparam logic [7:0] TICK_RESET   = 8'd50;
    localparam logic [7:0] EXCESS_RESET = 8'd100;

    // Window slots (each slot holds a low/high pair)
    localparam int W_HDR_MARK   = 0;
    localparam int W_BIT_MARK   = 1;
    localparam int W_HDR_SPACE  = 2;
    localparam int W_RPT_SPACE  = 3;
    localparam int W_ONE_SPACE  = 4;
    localparam int W_ZERO_SPACE = 5;

    // Fan codes
    localparam logic [CODE_BITS-1:0] CODE_TOGGLE = 32'h00ff22dd;
    localparam logic [CODE_BITS-1:0] CODE_UP     = 32'h00ff02fd;
    localparam logic [CODE_BITS-1:0] CODE_DOWN   = 32'h00ffc23d;
    localparam logic [2:0] SPEED_MAX = 3'd6;
    localparam logic [2:0] SPEED_MIN = 3'd1;

    typedef logic [DUR_W-1:0] win_val_t;
    typedef win_val_t [WIN_N-1:0] win_tbl_t;

    // Windows for tolerance 25, tick 50, excess 100 (lo, hi per slot)
    localparam win_tbl_t WIN_RESET = {
        16'd12,  16'd6,     // zero space
        16'd40,  16'd23,    // one space
        16'd54,  16'd32,    // repeat space
        16'd111, 16'd66,    // header space
        16'd17,  16'd9,     // bit mark
        16'd228, 16'd136    // header mark
    };

    // Nominal duration in us of a window slot
    function automatic logic [NOM_W-1:0] slot_nominal(input logic [2:0] slot);
        logic [NOM_W-1:0] nom;
        unique case (slot)
            3'd0:    nom = 14'd9000;
            3'd1:    nom = 14'd560;
            3'd2:    nom = 14'd4500;
            3'd3:    nom = 14'd2250;
            3'd4:    nom = 14'd1690;
            3'd5:    nom = 14'd560;
            default: nom = 14'd0;
        endcase
        return nom;
    endfunction

endpackage

FILE: rtl/nec_ir_decoder_fan_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nec_ir_decoder_fan_control
// NEC IR frame decoder with fan on/off and speed state.
// ----------------------------------------------------------------------------
// Path: an accepted beat is held in the input register; it then updates the
//   frame state and, on a last entry, the result (two-register path).
// Throughput: one duration per cycle while no result waits for m_tready. During
//   a config write and while the shared serial divider rebuilds the 12 window
//   bounds (a multiply load step, then 21 quotient bits each), the input stalls.
// Reset: windows load the default-config bounds at once; no clearing pass.
// ----------------------------------------------------------------------------
module nec_ir_decoder_fan_control
    import necfan_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // [15:0] duration_ticks, [16] motor_fault
    input  logic                  s_tlast,   // last_entry
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,   // [31:0] code_word, [32] fan_on,
                                             // [35:33] speed_level, [36] start_motor,
                                             // [37] stop_motor
    output logic [1:0]            m_tuser,   // [0] decode_ok, [1] is_repeat
    // config write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic                  calc_busy;
    win_tbl_t              win;

    // input stage
    logic                  s1_valid_reg;
    logic [DUR_W-1:0]      s1_dur_reg;
    logic                  s1_last_reg;
    logic                  s1_fault_reg;
    logic                  s1_fire;
    logic                  in_fire;

    // frame tracking
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  fgood_reg, fgood_next;
    logic                  rgood_reg, rgood_next;
    logic [CODE_BITS-1:0]  shift_reg, shift_next;
    logic                  fan_reg, fan_next;
    logic [2:0]            speed_reg, speed_next;

    // result register
    logic                  out_valid_reg;
    logic                  ok_reg, rep_reg, start_reg, stop_reg;
    logic [CODE_BITS-1:0]  code_reg;
    logic                  ok_next, rep_next, start_next, stop_next;
    logic [CODE_BITS-1:0]  code_next;

    // window hits
    logic                  hit_hm, hit_bm, hit_hs, hit_rs, hit_one, hit_zero;

    necfan_win_calc u_win_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (calc_busy),
        .win       (win)
    );

    // handshake
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !calc_busy && !cfg_we && (!s1_valid_reg || s1_fire);
    assign in_fire  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_dur_reg   <= s_tdata[DUR_W-1:0];
            s1_fault_reg <= s_tdata[DUR_W];
            s1_last_reg  <= s_tlast;
        end
    end

    // window compares
    assign hit_hm   = s1_dur_reg >= win[2*W_HDR_MARK]   && s1_dur_reg <= win[2*W_HDR_MARK+1];
    assign hit_bm   = s1_dur_reg >= win[2*W_BIT_MARK]   && s1_dur_reg <= win[2*W_BIT_MARK+1];
    assign hit_hs   = s1_dur_reg >= win[2*W_HDR_SPACE]  && s1_dur_reg <= win[2*W_HDR_SPACE+1];
    assign hit_rs   = s1_dur_reg >= win[2*W_RPT_SPACE]  && s1_dur_reg <= win[2*W_RPT_SPACE+1];
    assign hit_one  = s1_dur_reg >= win[2*W_ONE_SPACE]  && s1_dur_reg <= win[2*W_ONE_SPACE+1];
    assign hit_zero = s1_dur_reg >= win[2*W_ZERO_SPACE] && s1_dur_reg <= win[2*W_ZERO_SPACE+1];

    // per-beat decode and fan update
    always_comb
    begin
        idx_next   = idx_reg;
        fgood_next = fgood_reg;
        rgood_next = rgood_reg;
        shift_next = shift_reg;
        fan_next   = fan_reg;
        speed_next = speed_reg;
        ok_next    = 1'b0;
        rep_next   = 1'b0;
        start_next = 1'b0;
        stop_next  = 1'b0;
        code_next  = '0;

        // duration checks by position
        if (idx_reg == IDX_W'(1))
        begin
            if (!hit_hm)
            begin
                fgood_next = 1'b0;
                rgood_next = 1'b0;
            end
        end
        else if (idx_reg == IDX_W'(2))
        begin
            if (!hit_rs)
            begin
                rgood_next = 1'b0;
            end
            if (!hit_hs)
            begin
                fgood_next = 1'b0;
            end
        end
        else if (idx_reg >= IDX_W'(3) && idx_reg <= IDX_W'(LAST_DATA_ENTRY))
        begin
            if (idx_reg == IDX_W'(RPT_LAST_ENTRY) && !hit_bm)
            begin
                rgood_next = 1'b0;
            end
            // odd entries are bit marks, even ones bit spaces
            priority if (idx_reg[0])
            begin
                if (!hit_bm)
                begin
                    fgood_next = 1'b0;
                end
            end
            else if (hit_one)
            begin
                shift_next = {shift_reg[CODE_BITS-2:0], 1'b1};
            end
            else if (hit_zero)
            begin
                shift_next = {shift_reg[CODE_BITS-2:0], 1'b0};
            end
            else
            begin
                fgood_next = 1'b0;
            end
        end

        if (!s1_last_reg)
        begin
            if (idx_reg != IDX_W'(MAX_ENTRIES - 1))
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
        else
        begin
            // frame outcome
            priority if (idx_reg == IDX_W'(RPT_LAST_ENTRY) && rgood_next)
            begin
                ok_next  = 1'b1;
                rep_next = 1'b1;
            end
            else if (fgood_next && idx_reg >= IDX_W'(MIN_FRAME - 1))
            begin
                ok_next   = 1'b1;
                code_next = shift_next;
                priority if (shift_next == CODE_TOGGLE)
                begin
                    if (!fan_reg)
                    begin
                        if (!s1_fault_reg)
                        begin
                            fan_next   = 1'b1;
                            start_next = 1'b1;
                        end
                    end
                    else
                    begin
                        fan_next  = 1'b0;
                        stop_next = 1'b1;
                    end
                end
                else if (shift_next == CODE_UP)
                begin
                    speed_next = (speed_reg < SPEED_MAX) ? speed_reg + 1'b1 : SPEED_MAX;
                end
                else if (shift_next == CODE_DOWN)
                begin
                    speed_next = (speed_reg > SPEED_MIN) ? speed_reg - 1'b1 : speed_reg;
                    if (speed_next > SPEED_MAX)
                    begin
                        speed_next = SPEED_MAX;
                    end
                    if (speed_next < SPEED_MIN)
                    begin
                        speed_next = SPEED_MIN;
                    end
                end
            end
            // frame tracking back to idle
            idx_next   = '0;
            fgood_next = 1'b1;
            rgood_next = 1'b1;
            shift_next = '0;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            fgood_reg <= 1'b1;
            rgood_reg <= 1'b1;
            shift_reg <= '0;
            fan_reg   <= 1'b0;
            speed_reg <= SPEED_MIN;
        end
        else if (s1_fire)
        begin
            idx_reg   <= idx_next;
            fgood_reg <= fgood_next;
            rgood_reg <= rgood_next;
            shift_reg <= shift_next;
            fan_reg   <= fan_next;
            speed_reg <= speed_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
        begin
            ok_reg    <= ok_next;
            rep_reg   <= rep_next;
            code_reg  <= code_next;
            start_reg <= start_next;
            stop_reg  <= stop_next;
        end
    end

    // fan state in the result is the state after the frame
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {rep_reg, ok_reg};
    assign m_tdata  = {2'b00, stop_reg, start_reg, speed_reg, fan_reg, code_reg};

    // assertions
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> speed_reg >= SPEED_MIN && speed_reg <= SPEED_MAX)
        else $error("speed level out of range");

    a_start_stop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(start_reg && stop_reg) && (!start_reg || fan_reg)
                     && (!stop_reg || !fan_reg))
        else $error("motor command disagrees with fan state");

    a_repeat_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && rep_reg) |-> ok_reg && code_reg == '0)
        else $error("repeat result malformed");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_last_reg) |=> idx_reg == '0 && fgood_reg && rgood_reg)
        else $error("frame tracking not cleared after last entry");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (calc_busy && s_tvalid) |=> !s1_valid_reg || $stable(s1_dur_reg))
        else $error("beat taken while windows rebuild");

endmodule

FILE: rtl/necfan_win_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necfan_win_calc
// Config registers and the tick window table; recomputes all twelve window
// bounds with one shared restoring divider after each register write.
// ----------------------------------------------------------------------------
module necfan_win_calc
    import necfan_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  busy,
    output win_tbl_t              win
);

    typedef enum logic [2:0] {
        CS_IDLE = 3'b001,
        CS_LOAD = 3'b010,
        CS_DIV  = 3'b100
    } calc_state_t;

    calc_state_t        state_reg, state_next;
    logic [5:0]         tol_reg;
    logic [7:0]         tick_reg;
    logic [7:0]         excess_reg;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [BCNT_W-1:0]  bcnt_reg, bcnt_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    win_val_t           win_reg [WIN_N];

    logic               cfg_hit;
    logic               slot_is_mark;
    logic [NOM_W-1:0]   nominal;
    logic [NOM_W-1:0]   m_val;
    logic [7:0]         factor;
    logic [7:0]         tick_eff;
    logic [NUM_W:0]     prod;
    logic [DEN_W:0]     trial;
    logic               q_bit;
    logic [NUM_W-1:0]   quot;
    win_val_t           win_val;
    logic               win_we;

    // a write to a known register restarts the recompute
    assign cfg_hit = cfg_we && (cfg_index == CFG_TOLERANCE || cfg_index == CFG_TICK
                                || cfg_index == CFG_MARK_EXCESS);

    // numerator and denominator of the current slot
    assign slot_is_mark = (slot_reg[SLOT_W-1:1] == 3'(W_HDR_MARK))
                       || (slot_reg[SLOT_W-1:1] == 3'(W_BIT_MARK));
    assign nominal  = slot_nominal(slot_reg[SLOT_W-1:1]);
    assign m_val    = slot_is_mark ? nominal + {6'd0, excess_reg}
                                   : nominal - {6'd0, excess_reg};
    assign factor   = slot_reg[0] ? 8'd100 + {2'd0, tol_reg} : 8'd100 - {2'd0, tol_reg};
    assign tick_eff = (tick_reg == 8'd0) ? 8'd1 : tick_reg;
    assign prod     = {8'd0, m_val} * {14'd0, factor};

    // one restoring step per cycle
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign q_bit = (trial >= {1'b0, den_reg});
    assign quot  = {num_reg[NUM_W-2:0], q_bit};
    assign win_val = quot[DUR_W-1:0] + {{(DUR_W-1){1'b0}}, slot_reg[0]};
    assign win_we  = (state_reg == CS_DIV) && (bcnt_reg == BCNT_W'(NUM_W - 1));

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        bcnt_next  = bcnt_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        unique case (state_reg)
            CS_IDLE:
            begin
            end
            CS_LOAD:
            begin
                num_next   = prod[NUM_W-1:0];
                den_next   = {7'd0, tick_eff} * 15'd100;
                rem_next   = '0;
                bcnt_next  = '0;
                state_next = CS_DIV;
            end
            CS_DIV:
            begin
                num_next = quot;
                rem_next = q_bit ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
                bcnt_next = bcnt_reg + 1'b1;
                if (win_we)
                begin
                    if (slot_reg == SLOT_W'(WIN_N - 1))
                    begin
                        state_next = CS_IDLE;
                    end
                    else
                    begin
                        slot_next  = slot_reg + 1'b1;
                        state_next = CS_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
        if (cfg_hit)
        begin
            state_next = CS_LOAD;
            slot_next  = '0;
        end
    end

    // control and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= CS_IDLE;
            slot_reg   <= '0;
            bcnt_reg   <= '0;
            tol_reg    <= TOL_RESET;
            tick_reg   <= TICK_RESET;
            excess_reg <= EXCESS_RESET;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            bcnt_reg  <= bcnt_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TOLERANCE:   tol_reg    <= cfg_data[5:0];
                    CFG_TICK:        tick_reg   <= cfg_data;
                    CFG_MARK_EXCESS: excess_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // divider datapath
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    // window table, reset to the default-config bounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_N; i++)
            begin
                win_reg[i] <= WIN_RESET[i];
            end
        end
        else if (win_we)
        begin
            win_reg[slot_reg] <= win_val;
        end
    end

    always_comb
    begin
        for (int i = 0; i < WIN_N; i++)
        begin
            win[i] = win_reg[i];
        end
    end

    assign busy = (state_reg != CS_IDLE);

    // assertions
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> slot_reg < SLOT_W'(WIN_N))
        else $error("window slot out of range");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> state_reg == CS_LOAD && slot_reg == '0)
        else $error("config write did not restart window calc");

    a_load_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CS_LOAD && !cfg_hit) |=> state_reg == CS_DIV && bcnt_reg == '0)
        else $error("divide did not follow load");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CS_DIV && bcnt_reg != '0) |-> rem_reg < den_reg)
        else $error("divider remainder not below divisor");

endmodule
